@@ rtl/sbd_pkg.sv @@
// Shared types and constants for the shuffle bag draw block.
// Used by sbd_ctrl, sbd_dp, the top level and the port checker.
// No dependencies.
package sbd_pkg;

  localparam int BAG_DEPTH   = 1024;
  localparam int IDX_W       = $clog2(BAG_DEPTH);
  localparam int CNT_W       = 11;
  localparam int DATA_W      = 32;
  localparam int RND_W       = 16;
  localparam int DIV_CNT_W   = $clog2(RND_W);
  localparam int MODE_W      = 3;
  localparam int STAT_W      = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - CNT_W;

  localparam logic [CNT_W-1:0] BAG_SIZE_RST = CNT_W'(1024);
  localparam logic [CNT_W-1:0] DEPTH_CNT    = CNT_W'(BAG_DEPTH);

  typedef enum logic [MODE_W-1:0] {
    MODE_DRAW  = 3'd0,
    MODE_OPEN  = 3'd1,
    MODE_LOAD  = 3'd2,
    MODE_CLOSE = 3'd3,
    MODE_FILL  = 3'd4
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_EMPTY  = 2'd2
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic div_step;
    logic grab_drawn;
    logic rd_last;
    logic wr_draw;
    logic open_load;
    logic close_load;
    logic load_val;
    logic err_empty;
    logic err_load;
    logic fill_step;
    logic fill_done;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              ccnt_zero;
    logic              load_ok;
    logic              fill_end;
    logic              div_last;
    logic              out_free;
  } stat_t;

endpackage

@@ rtl/shuffle_bag_draw.sv @@
// Top level of the shuffle bag draw block: two-bag draw without replacement.
// Instantiates sbd_ctrl and sbd_dp; depends on sbd_pkg.
//
//  channel | direction | tdata (low bit up)                     | tuser
//  s_axis  | in        | load_value[31:0], random_word[47:32]  | mode[2:0]
//  m_axis  | out       | drawn_value[31:0], remaining[42:32],  | status[1:0]
//          |           | zero pad[47:43]                        |
//  cfg     | in        | cfg_wdata_i = bag_size[10:0], cfg_we_i | -
//
// A draw passes from acceptance through decode, the bit-serial modulo, two memory reads,
// the writes into both bags and the output register load. Fill identity makes one memory
// write per entry for min(bag_size, 1024) entries; other modes and an empty draw go from
// decode straight to the result. One transaction is in progress at a time.
// Reset empties both bags and closes loading; the bag memories are not cleared.
// A stalled result holds the output; one more transaction is accepted behind it.
module shuffle_bag_draw (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sbd_pkg::CNT_W-1:0]           cfg_wdata_i,   // bag_size
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [sbd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // load_value, random_word
  input  logic [sbd_pkg::MODE_W-1:0]          s_axis_tuser,  // mode
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [sbd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // drawn_value, remaining, pad
  output logic [sbd_pkg::STAT_W-1:0]          m_axis_tuser   // status
);

  sbd_pkg::cmd_t  cmd;
  sbd_pkg::stat_t stat;

  sbd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  sbd_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

@@ rtl/sbd_ctrl.sv @@
// Controller state machine for the shuffle bag draw block.
// Sequences draw, load and fill transactions; depends on sbd_pkg.
module sbd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  sbd_pkg::stat_t stat_i,
  output sbd_pkg::cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_DECODE  = 8'b0000_0010,
    ST_DIV     = 8'b0000_0100,
    ST_RD_PICK = 8'b0000_1000,
    ST_RD_LAST = 8'b0001_0000,
    ST_WR      = 8'b0010_0000,
    ST_FILL    = 8'b0100_0000,
    ST_RESULT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_RESULT;
        unique case (sbd_pkg::mode_e'(stat_i.mode))
          sbd_pkg::MODE_DRAW: begin
            if (stat_i.ccnt_zero) begin
              cmd_o.err_empty = 1'b1;
            end else begin
              state_d = ST_DIV;
            end
          end
          sbd_pkg::MODE_OPEN:  cmd_o.open_load = 1'b1;
          sbd_pkg::MODE_LOAD: begin
            if (stat_i.load_ok) begin
              cmd_o.load_val = 1'b1;
            end else begin
              cmd_o.err_load = 1'b1;
            end
          end
          sbd_pkg::MODE_CLOSE: cmd_o.close_load = 1'b1;
          sbd_pkg::MODE_FILL:  state_d = ST_FILL;
          default: ;
        endcase
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_RD_PICK;
        end
      end
      // memory read of the picked entry is in flight
      ST_RD_PICK: state_d = ST_RD_LAST;
      ST_RD_LAST: begin
        cmd_o.grab_drawn = 1'b1;
        cmd_o.rd_last    = 1'b1;
        state_d          = ST_WR;
      end
      ST_WR: begin
        cmd_o.wr_draw = 1'b1;
        state_d       = ST_RESULT;
      end
      ST_FILL: begin
        if (stat_i.fill_end) begin
          cmd_o.fill_done = 1'b1;
          state_d         = ST_RESULT;
        end else begin
          cmd_o.fill_step = 1'b1;
        end
      end
      ST_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/sbd_dp.sv @@
// Datapath for the shuffle bag draw block: two bag memories, counts,
// serial modulo unit and output register. Depends on sbd_pkg.
module sbd_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sbd_pkg::CNT_W-1:0]            cfg_wdata_i,
  input  logic [sbd_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  input  logic [sbd_pkg::MODE_W-1:0]           s_axis_tuser,
  input  sbd_pkg::cmd_t                        cmd_i,
  output sbd_pkg::stat_t                       stat_o,
  input  logic                                 m_axis_tready,
  output logic                                 m_axis_tvalid,
  output logic [sbd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic [sbd_pkg::STAT_W-1:0]           m_axis_tuser
);

  localparam int CW = sbd_pkg::CNT_W;
  localparam int IW = sbd_pkg::IDX_W;
  localparam int DW = sbd_pkg::DATA_W;
  localparam int RW = sbd_pkg::RND_W;

  logic [DW-1:0] mem0 [sbd_pkg::BAG_DEPTH];
  logic [DW-1:0] mem1 [sbd_pkg::BAG_DEPTH];
  logic [DW-1:0] rdata0_q, rdata1_q;

  logic [CW-1:0] cnt0_q, cnt0_d, cnt1_q, cnt1_d;
  logic          cur_q, cur_d;
  logic          load_open_q, load_open_d;
  logic [CW-1:0] bag_size_q;
  logic          m_valid_q;

  logic [sbd_pkg::MODE_W-1:0]    mode_q;
  logic [DW-1:0]                 lval_q;
  logic [RW-1:0]                 rnd_q;
  logic [CW-1:0]                 rem_q;
  logic [sbd_pkg::DIV_CNT_W-1:0] div_cnt_q;
  logic [CW-1:0]                 fill_idx_q;
  logic [DW-1:0]                 drawn_q;
  logic [sbd_pkg::STAT_W-1:0]    status_q;
  logic [DW-1:0]                 out_drawn_q;
  logic [CW-1:0]                 out_rem_q;
  logic [sbd_pkg::STAT_W-1:0]    out_status_q;

  logic [CW-1:0] ccnt, ncnt, ccnt_m1, lim, ccnt_new, ncnt_new;
  logic [CW:0]   trial, diff;
  logic [CW-1:0] rem_d;
  logic [DW-1:0] crd;
  logic          ncnt_room;
  logic [IW-1:0] raddr;
  logic          cw_en, nw_en;
  logic [IW-1:0] cw_addr, nw_addr;
  logic [DW-1:0] cw_data;
  logic          we0, we1;
  logic [IW-1:0] waddr0, waddr1;
  logic [DW-1:0] wdata0, wdata1;
  logic          out_free;

  assign ccnt      = cur_q ? cnt1_q : cnt0_q;
  assign ncnt      = cur_q ? cnt0_q : cnt1_q;
  assign ccnt_m1   = ccnt - CW'(1);
  assign lim       = (bag_size_q > sbd_pkg::DEPTH_CNT) ? sbd_pkg::DEPTH_CNT : bag_size_q;
  assign ncnt_room = ncnt < sbd_pkg::DEPTH_CNT;
  assign crd       = cur_q ? rdata1_q : rdata0_q;
  assign out_free  = !m_valid_q || m_axis_tready;

  // Restoring division step: one quotient bit per cycle, keep the remainder only
  assign trial = {rem_q, rnd_q[RW-1]};
  assign diff  = trial - {1'b0, ccnt};
  assign rem_d = (trial >= {1'b0, ccnt}) ? diff[CW-1:0] : trial[CW-1:0];

  assign raddr = cmd_i.rd_last ? ccnt_m1[IW-1:0] : rem_q[IW-1:0];

  // Current-bag and other-bag write ports
  always_comb begin
    cw_en   = 1'b0;
    cw_addr = rem_q[IW-1:0];
    cw_data = crd;
    if (cmd_i.wr_draw) begin
      cw_en = ccnt_m1 != '0;
    end else if (cmd_i.load_val) begin
      cw_en   = 1'b1;
      cw_addr = ccnt[IW-1:0];
      cw_data = lval_q;
    end else if (cmd_i.fill_step) begin
      cw_en   = 1'b1;
      cw_addr = fill_idx_q[IW-1:0];
      cw_data = DW'(fill_idx_q);
    end
  end

  assign nw_en   = cmd_i.wr_draw && ncnt_room;
  assign nw_addr = ncnt[IW-1:0];

  assign we0    = cur_q ? nw_en   : cw_en;
  assign waddr0 = cur_q ? nw_addr : cw_addr;
  assign wdata0 = cur_q ? drawn_q : cw_data;
  assign we1    = cur_q ? cw_en   : nw_en;
  assign waddr1 = cur_q ? cw_addr : nw_addr;
  assign wdata1 = cur_q ? cw_data : drawn_q;

  always_ff @(posedge clk_i) begin
    if (we0) begin
      mem0[waddr0] <= wdata0;
    end
    rdata0_q <= mem0[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (we1) begin
      mem1[waddr1] <= wdata1;
    end
    rdata1_q <= mem1[raddr];
  end

  // Count, bag role and load state updates
  always_comb begin
    ccnt_new    = ccnt;
    ncnt_new    = ncnt;
    cur_d       = cur_q;
    load_open_d = load_open_q;
    if (cmd_i.open_load) begin
      ccnt_new    = '0;
      ncnt_new    = '0;
      load_open_d = 1'b1;
    end
    if (cmd_i.close_load) begin
      load_open_d = 1'b0;
    end
    if (cmd_i.load_val) begin
      ccnt_new = ccnt + CW'(1);
    end
    if (cmd_i.wr_draw) begin
      if (ncnt_room) begin
        ncnt_new = ncnt + CW'(1);
      end
      ccnt_new = ccnt_m1;
      if (ccnt_m1 == '0) begin
        cur_d = ~cur_q;
      end
    end
    if (cmd_i.fill_done) begin
      ccnt_new = lim;
      ncnt_new = '0;
    end
    cnt0_d = cur_q ? ncnt_new : ccnt_new;
    cnt1_d = cur_q ? ccnt_new : ncnt_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt0_q      <= '0;
      cnt1_q      <= '0;
      cur_q       <= 1'b0;
      load_open_q <= 1'b0;
      bag_size_q  <= sbd_pkg::BAG_SIZE_RST;
      m_valid_q   <= 1'b0;
    end else begin
      cnt0_q      <= cnt0_d;
      cnt1_q      <= cnt1_d;
      cur_q       <= cur_d;
      load_open_q <= load_open_d;
      if (cfg_we_i) begin
        bag_size_q <= cfg_wdata_i;
      end
      if (cmd_i.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q     <= s_axis_tuser;
      lval_q     <= s_axis_tdata[DW-1:0];
      rnd_q      <= s_axis_tdata[DW +: RW];
      rem_q      <= '0;
      div_cnt_q  <= '0;
      fill_idx_q <= '0;
      drawn_q    <= '0;
      status_q   <= sbd_pkg::STAT_OK;
    end
    if (cmd_i.div_step) begin
      rem_q     <= rem_d;
      rnd_q     <= {rnd_q[RW-2:0], 1'b0};
      div_cnt_q <= div_cnt_q + sbd_pkg::DIV_CNT_W'(1);
    end
    if (cmd_i.grab_drawn) begin
      drawn_q <= crd;
    end
    if (cmd_i.fill_step) begin
      fill_idx_q <= fill_idx_q + CW'(1);
    end
    if (cmd_i.err_empty) begin
      status_q <= sbd_pkg::STAT_EMPTY;
    end
    if (cmd_i.err_load) begin
      status_q <= sbd_pkg::STAT_REJECT;
    end
    if (cmd_i.out_load) begin
      out_drawn_q  <= drawn_q;
      out_status_q <= status_q;
      out_rem_q    <= ccnt;
    end
  end

  assign stat_o.mode      = mode_q;
  assign stat_o.ccnt_zero = ccnt == '0;
  assign stat_o.load_ok   = load_open_q && (ccnt < lim);
  assign stat_o.fill_end  = fill_idx_q >= lim;
  assign stat_o.div_last  = div_cnt_q == sbd_pkg::DIV_CNT_W'(RW - 1);
  assign stat_o.out_free  = out_free;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{sbd_pkg::OUT_PAD_W{1'b0}}, out_rem_q, out_drawn_q};
  assign m_axis_tuser  = out_status_q;

endmodule

@@ rtl/sbd_checker.sv @@
// Port checker for shuffle_bag_draw, attached by the bind below.
// Depends on sbd_pkg.
module sbd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [sbd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [sbd_pkg::STAT_W-1:0]      m_axis_tuser
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // One transaction at a time: drop ready after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted during a transaction");

  // A failed step returns zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != sbd_pkg::STAT_OK) |->
      m_axis_tdata[sbd_pkg::DATA_W-1:0] == '0)
    else $error("nonzero value with error status");

  // Remaining never exceeds the bag depth, padding stays zero
  a_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      m_axis_tdata[sbd_pkg::DATA_W +: sbd_pkg::CNT_W] <= sbd_pkg::DEPTH_CNT &&
      m_axis_tdata[sbd_pkg::OUT_TDATA_W-1 -: sbd_pkg::OUT_PAD_W] == '0)
    else $error("remaining out of range or padding set");

endmodule

bind shuffle_bag_draw sbd_checker u_sbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ bench/shuffle_bag_draw_tb.sv @@
// Self-checking bench for shuffle_bag_draw: directed corner cases, then
// random command sequences.
// Depends on sbd_pkg and the shuffle_bag_draw RTL only.
`timescale 1ns / 1ps

module shuffle_bag_draw_tb;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 1060;
  localparam logic [sbd_pkg::MODE_W-1:0] MODE_SPARE_5 = 3'd5;
  localparam logic [sbd_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [sbd_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  typedef struct {
    logic [sbd_pkg::DATA_W-1:0] drawn;
    sbd_pkg::status_e           status;
    logic [sbd_pkg::CNT_W-1:0]  remaining;
  } draw_result_t;

  // Tracks both bags and checks every result against the oldest expectation
  class bag_draw_checker;
    logic [sbd_pkg::DATA_W-1:0] bags [2][sbd_pkg::BAG_DEPTH];
    int unsigned       counts [2];
    bit                cur_bag;
    bit                load_open;
    int unsigned       bag_size;
    draw_result_t      expected_draws [$];
    int unsigned       mismatches, checked, draws, swaps, empties, rejects, saturated;

    function new();
      counts[0] = 0;
      counts[1] = 0;
      cur_bag   = 1'b0;
      load_open = 1'b0;
      bag_size  = 1024;
    endfunction

    function void set_size(logic [sbd_pkg::CNT_W-1:0] size);
      bag_size = size;
    endfunction

    function int unsigned pending();
      return expected_draws.size();
    endfunction

    function void note_item(logic [sbd_pkg::MODE_W-1:0] mode_bits,
                            logic [sbd_pkg::DATA_W-1:0] lval,
                            logic [sbd_pkg::RND_W-1:0] rnd);
      draw_result_t res;
      int unsigned  lim, pick;
      bit           nxt;
      lim        = (bag_size < sbd_pkg::BAG_DEPTH) ? bag_size : sbd_pkg::BAG_DEPTH;
      nxt        = !cur_bag;
      res.drawn  = '0;
      res.status = sbd_pkg::STAT_OK;
      case (mode_bits)
        sbd_pkg::MODE_DRAW: begin
          if (counts[cur_bag] == 0) begin
            res.status = sbd_pkg::STAT_EMPTY;
            empties++;
          end else begin
            pick      = 32'(rnd) % counts[cur_bag];
            res.drawn = bags[cur_bag][pick];
            draws++;
            // the other bag stops growing once it holds BAG_DEPTH entries
            if (counts[nxt] < sbd_pkg::BAG_DEPTH) begin
              bags[nxt][counts[nxt]] = res.drawn;
              counts[nxt]++;
            end else begin
              saturated++;
            end
            counts[cur_bag]--;
            if (counts[cur_bag] != 0) begin
              bags[cur_bag][pick] = bags[cur_bag][counts[cur_bag]];
            end else begin
              cur_bag = nxt;
              swaps++;
            end
          end
        end
        sbd_pkg::MODE_OPEN: begin
          load_open = 1'b1;
          counts[0] = 0;
          counts[1] = 0;
        end
        sbd_pkg::MODE_LOAD: begin
          if (!load_open || counts[cur_bag] >= lim) begin
            res.status = sbd_pkg::STAT_REJECT;
            rejects++;
          end else begin
            bags[cur_bag][counts[cur_bag]] = lval;
            counts[cur_bag]++;
          end
        end
        sbd_pkg::MODE_CLOSE: load_open = 1'b0;
        sbd_pkg::MODE_FILL: begin
          for (int unsigned i = 0; i < lim; i++) bags[cur_bag][i] = sbd_pkg::DATA_W'(i);
          counts[cur_bag] = lim;
          counts[nxt]     = 0;
        end
        default: ;
      endcase
      res.remaining = sbd_pkg::CNT_W'(counts[cur_bag]);
      expected_draws.push_back(res);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("ERROR at %0t: result %0d %s", $time, checked, what);
    endtask

    task check_result(logic [sbd_pkg::DATA_W-1:0] drawn, logic [sbd_pkg::STAT_W-1:0] status,
                      logic [sbd_pkg::CNT_W-1:0] remaining);
      draw_result_t want;
      if (expected_draws.size() == 0) begin
        report_mismatch("arrived with no transaction outstanding");
      end else begin
        want = expected_draws.pop_front();
        if (drawn !== want.drawn)
          report_mismatch($sformatf("drawn_value %h, want %h", drawn, want.drawn));
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (remaining !== want.remaining)
          report_mismatch($sformatf("remaining %0d, want %0d", remaining, want.remaining));
      end
      checked++;
    endtask
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [sbd_pkg::CNT_W-1:0]       cfg_wdata_i;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [sbd_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic [sbd_pkg::MODE_W-1:0]      s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [sbd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [sbd_pkg::STAT_W-1:0]      m_axis_tuser;

  bag_draw_checker board = new();
  bit              idling_on = 1'b1;
  int unsigned     rx_hold_len = 0;
  int unsigned     cycle_count = 0;
  int unsigned     active_items = 0;
  int unsigned     size_writes = 0;

  shuffle_bag_draw u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               board.pending());
      $display("shuffle_bag_draw: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tdata[sbd_pkg::DATA_W-1:0], m_axis_tuser,
                         m_axis_tdata[sbd_pkg::DATA_W+sbd_pkg::CNT_W-1:sbd_pkg::DATA_W]);
  end

  // Result side: random stalls, plus long hold-offs on request
  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (rx_hold_len != 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold_len) @(negedge clk_i);
        rx_hold_len = 0;
        m_axis_tready <= 1'b1;
      end else if (idling_on && $urandom_range(0, 6) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Call at a falling edge; returns at a falling edge with tvalid possibly still high
  task automatic push_item(logic [sbd_pkg::MODE_W-1:0] mode_bits,
                           logic [sbd_pkg::DATA_W-1:0] lval,
                           logic [sbd_pkg::RND_W-1:0] rnd);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rnd, lval};
    s_axis_tuser  <= mode_bits;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_item(mode_bits, lval, rnd);
    if (mode_bits <= sbd_pkg::MODE_FILL) active_items++;
    @(negedge clk_i);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
  endtask

  task automatic push_draw();
    push_item(sbd_pkg::MODE_DRAW, $urandom, sbd_pkg::RND_W'($urandom));
  endtask

  task automatic push_any();
    push_item(sbd_pkg::MODE_W'($urandom_range(0, 7)), $urandom, sbd_pkg::RND_W'($urandom));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_bag_size(logic [sbd_pkg::CNT_W-1:0] size);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size;
    board.set_size(size);
    size_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_phase();
    logic [sbd_pkg::CNT_W-1:0] size;
    int unsigned               lim, n, kind;
    wait_drained();
    case ($urandom_range(0, 9))
      0: size = '0;
      1: size = sbd_pkg::CNT_W'($urandom_range(13, 64));
      2: begin
        case ($urandom_range(0, 3))
          0:       size = sbd_pkg::CNT_W'(1023);
          1:       size = sbd_pkg::CNT_W'(1024);
          2:       size = sbd_pkg::CNT_W'(2047);
          default: size = sbd_pkg::CNT_W'($urandom_range(1025, 2047));
        endcase
      end
      default: size = sbd_pkg::CNT_W'($urandom_range(1, 12));
    endcase
    write_bag_size(size);
    lim  = (size < sbd_pkg::BAG_DEPTH) ? size : sbd_pkg::BAG_DEPTH;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      // fill, then draw the bag out and into the next one
      push_item(sbd_pkg::MODE_FILL, $urandom, sbd_pkg::RND_W'($urandom));
      n = $urandom_range(1, 2 * lim + 3);
      if (n > 40) n = 40;
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) push_any();
        else push_draw();
      end
    end else if (kind < 8) begin
      // open, load a few values (past full sometimes), usually close, then draw
      push_item(sbd_pkg::MODE_OPEN, $urandom, sbd_pkg::RND_W'($urandom));
      n = $urandom_range(0, lim + 2);
      if (n > 24) n = 24;
      repeat (n) begin
        push_item(sbd_pkg::MODE_LOAD, $urandom, sbd_pkg::RND_W'($urandom));
        if ($urandom_range(0, 4) == 0) push_draw();
      end
      if ($urandom_range(0, 3) != 0)
        push_item(sbd_pkg::MODE_CLOSE, $urandom, sbd_pkg::RND_W'($urandom));
      repeat ($urandom_range(1, 2 * n + 2)) begin
        if ($urandom_range(0, 9) == 0) push_any();
        else push_draw();
      end
      if ($urandom_range(0, 2) == 0)
        push_item(sbd_pkg::MODE_LOAD, $urandom, sbd_pkg::RND_W'($urandom));
    end else begin
      repeat ($urandom_range(8, 24)) push_any();
    end
  endtask

  initial begin
    int unsigned start_items, phase_no;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = sbd_pkg::MODE_DRAW;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty draw, closed load, spare modes, full-size fill at reset size
    push_item(sbd_pkg::MODE_DRAW, 32'h0000_0000, 16'h0000);
    push_item(sbd_pkg::MODE_LOAD, 32'h8000_0000, 16'hFFFF);
    push_item(MODE_SPARE_5, 32'hFFFF_FFFF, 16'hFFFF);
    push_item(MODE_SPARE_6, 32'h0000_0000, 16'h0000);
    push_item(MODE_SPARE_7, 32'hA5A5_5A5A, 16'h5AA5);
    push_item(sbd_pkg::MODE_FILL, 32'h0000_0000, 16'h0000);
    push_item(sbd_pkg::MODE_DRAW, 32'h0000_0000, 16'hFFFF);
    push_item(sbd_pkg::MODE_DRAW, 32'h0000_0000, 16'h0000);
    push_item(sbd_pkg::MODE_CLOSE, 32'h0000_0000, 16'h0000);
    push_item(sbd_pkg::MODE_OPEN, 32'h0000_0000, 16'h0000);
    push_item(sbd_pkg::MODE_LOAD, 32'h7FFF_FFFF, 16'h0000);
    push_item(sbd_pkg::MODE_LOAD, 32'h8000_0000, 16'h0000);
    push_item(sbd_pkg::MODE_LOAD, 32'h0000_0000, 16'h0000);
    push_item(sbd_pkg::MODE_LOAD, 32'hFFFF_FFFF, 16'h0000);
    push_item(sbd_pkg::MODE_DRAW, 32'h0000_0000, 16'hFFFF);
    push_item(sbd_pkg::MODE_CLOSE, 32'h0000_0000, 16'h0000);
    push_item(sbd_pkg::MODE_LOAD, 32'h1234_5678, 16'h0000);
    // two-entry bag: reject when full, single-entry draw swaps bags
    wait_drained();
    write_bag_size(sbd_pkg::CNT_W'(2));
    push_item(sbd_pkg::MODE_OPEN, 32'h0, 16'h0);
    push_item(sbd_pkg::MODE_LOAD, 32'hDEAD_BEEF, 16'h0);
    push_item(sbd_pkg::MODE_LOAD, 32'h0BAD_F00D, 16'h0);
    push_item(sbd_pkg::MODE_LOAD, 32'h5555_5555, 16'h0);
    push_item(sbd_pkg::MODE_CLOSE, 32'h0, 16'h0);
    repeat (4) push_draw();
    // zero size: fill leaves an empty bag, loads refused
    wait_drained();
    write_bag_size('0);
    push_item(sbd_pkg::MODE_FILL, 32'h0, 16'h0);
    push_item(sbd_pkg::MODE_OPEN, 32'h0, 16'h0);
    push_item(sbd_pkg::MODE_LOAD, 32'h1, 16'h0);
    push_item(sbd_pkg::MODE_DRAW, 32'h0, 16'h7FFF);
    push_item(sbd_pkg::MODE_CLOSE, 32'h0, 16'h0);
    // size beyond the depth clamps to BAG_DEPTH
    wait_drained();
    write_bag_size(sbd_pkg::CNT_W'(2047));
    push_item(sbd_pkg::MODE_FILL, 32'h0, 16'h0);
    push_item(sbd_pkg::MODE_DRAW, 32'h0, 16'hFFFF);

    // Random command sequences; idling stops for the last stretch
    start_items = active_items;
    phase_no    = 0;
    while (active_items - start_items < RANDOM_ITEMS) begin
      idling_on = (active_items - start_items < RANDOM_ITEMS - 200) &&
                  ($urandom_range(0, 3) != 0);
      random_phase();
      phase_no++;
      if ((phase_no == 4 || phase_no == 20) &&
          (active_items - start_items < RANDOM_ITEMS - 200)) begin
        // hold the result side off long enough to back up the input
        rx_hold_len = 200;
        repeat (12) begin
          if ($urandom_range(0, 3) == 0) push_any();
          else push_draw();
        end
      end
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("run: %0d commands, %0d results checked, %0d bag_size writes",
             active_items, board.checked, size_writes);
    $display("run: %0d draws, %0d bag swaps, %0d empty draws, %0d refused loads, %0d drops",
             board.draws, board.swaps, board.empties, board.rejects, board.saturated);
    if (board.mismatches == 0) begin
      $display("shuffle_bag_draw: match");
    end else begin
      $display("shuffle_bag_draw: mismatch");
    end
    $finish;
  end

endmodule
